// File: rtl/core/swbp_pkg.sv
// ----------------------------------------------------------------------------
// swbp_pkg: shared types and constants of the sagging wire point unit
// Widths, fixed point constants, sequencer states and divider status.
// ----------------------------------------------------------------------------
package swbp_pkg;

    localparam int COORD_W    = 20;   // coordinate width
    localparam int MID_W      = 23;   // middle point width, holds the sag
    localparam int DIV_W      = 21;   // divider operand width
    localparam int DIV_CNT_W  = 5;    // divider step counter width
    localparam int MUL_A_W    = 28;   // multiplier operand a (signed)
    localparam int MUL_B_W    = 24;   // multiplier operand b (signed)
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = 7;    // holds MAX_POINTS itself
    localparam int IDX_W      = 6;    // point index
    localparam int FX_SHIFT   = 12;   // 1/4096 fixed point
    localparam int ONE_FX     = 4096;
    localparam int BIG_LIMIT  = 4096; // axis delta limit before prescale
    localparam int BIG_SHIFT  = 8;    // prescale by 0x100

    // config register indexes
    localparam logic CFG_SEG_LEN = 1'b0;
    localparam logic CFG_SAG_DIV = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DELTA,
        S_SQ,
        S_ROOT,
        S_DIVL_GO,
        S_DIVL_WAIT,
        S_DIVS_GO,
        S_DIVS_WAIT,
        S_ECNT0,
        S_ECNT1,
        S_PDIV_GO,
        S_PDIV_WAIT,
        S_TT0,
        S_TT1,
        S_AXIS,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/core/swbp_divider.sv
// ----------------------------------------------------------------------------
// swbp_divider: unsigned restoring divider
// One quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module swbp_divider import swbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output t_div_stat        o_stat
);

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W:0]       shifted;
    logic                 fits;

    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIV_W'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[DIV_W-1:0];
            end
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: rtl/core/sagging_wire_bezier_points_unit.sv
// ----------------------------------------------------------------------------
// sagging_wire_bezier_points_unit: quadratic Bezier points along a wire
// Distance by integer square root, segment count, sagging midpoint, and
// the curve points from weights in 1/4096 fixed point, one stream word per point.
// ----------------------------------------------------------------------------
// One input word describes a wire: start, end, an optional middle control
// point (tuser = 1 uses it, 0 derives a midpoint that sags by
// distance / sag_divisor in y) and the drawn fraction reach (4096 = whole).
// The unit measures the distance (deltas prescaled by 256 when any axis
// exceeds 4096), splits it into distance / segment_length segments and
// streams min(segments * reach / 4096, 64) points, the final one with
// tlast; a wire that yields no point produces no output word. It handles
// one wire at a time. Per wire it runs a 13 step square root and two
// divisions, and per point one division plus ten uses of the single
// shared 28x24 multiplier. Register 0 is segment_length, register 1
// sag_divisor; a zero in either acts as 1.
module sagging_wire_bezier_points_unit import swbp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, mid_x, mid_y, mid_z,
    // reach, zero fill
    input  logic [199:0] i_s_axis_tdata,
    // mid_given
    input  logic [0:0]   i_s_axis_tuser,
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // point_x, point_y, point_z, point_index, zero fill
    output logic [71:0]  o_m_axis_tdata,
    output logic         o_m_axis_tlast
);

    t_state r_state, n_state;

    logic [15:0] r_seg_len;
    logic [15:0] r_sag_div;

    logic signed [COORD_W-1:0] r_s [3];
    logic signed [COORD_W-1:0] r_e [3];
    logic signed [MID_W-1:0]   r_m [3];
    logic                      r_mid_given;
    logic [12:0]               r_reach;
    logic signed [DIV_W-1:0]   r_d [3];
    logic                      r_big;

    logic [1:0]                r_t;
    logic [1:0]                r_j;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  r_prod;

    logic [25:0]               r_rn;
    logic [26:0]               r_root;
    logic [24:0]               r_bit;
    logic [DIV_W-1:0]          r_dist;
    logic [DIV_W-1:0]          r_lcount;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_k;
    logic signed [COORD_W-1:0] r_tq;
    logic [24:0]               r_r;
    logic signed [MUL_A_W-1:0] r_we;
    logic signed [MUL_A_W-1:0] r_wm;
    logic signed [COORD_W-1:0] r_p [3];

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      div_start;
    logic [DIV_W-1:0]          div_num;
    logic [DIV_W-1:0]          div_den;
    logic [DIV_W-1:0]          div_quo;
    t_div_stat                 div_stat;

    logic                      in_acc;
    logic                      out_acc;
    logic                      last_pt;

    // delta prescale
    logic signed [DIV_W-1:0]   d_raw [3];
    logic signed [DIV_W-1:0]   d_div [3];
    logic                      big_c;

    // square root step
    logic [26:0]               trial;
    logic                      take;
    logic [26:0]               root_nx;

    // midpoint
    logic signed [DIV_W-1:0]   mid_sum [3];
    logic signed [COORD_W-1:0] mid_half [3];

    // point finish
    logic signed [PROD_W-1:0]  fin_sum;
    logic signed [PROD_W-1:0]  fin_q;
    logic signed [COORD_W-1:0] fin_p;
    logic [PROD_W-FX_SHIFT-1:0] ecnt_raw;

    logic [15:0] seg_eff;
    logic [15:0] sag_eff;

    assign seg_eff = (r_seg_len == 16'd0) ? 16'd1 : r_seg_len;
    assign sag_eff = (r_sag_div == 16'd0) ? 16'd1 : r_sag_div;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign last_pt = ({1'b0, r_k} + CNT_W'(1)) == r_cnt;

    swbp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    // deltas, prescaled by 256 toward zero when any axis is large
    always_comb begin
        big_c = 1'b0;
        for (int k = 0; k < 3; k++) begin
            d_raw[k] = DIV_W'(r_s[k]) - DIV_W'(r_e[k]);
            if ((d_raw[k] > DIV_W'(BIG_LIMIT)) || (d_raw[k] < -DIV_W'(BIG_LIMIT))) begin
                big_c = 1'b1;
            end
            d_div[k] = (d_raw[k] + (d_raw[k][DIV_W-1] ? DIV_W'(255) : DIV_W'(0)))
                       >>> BIG_SHIFT;
            mid_sum[k]  = DIV_W'(r_s[k]) + DIV_W'(r_e[k]);
            mid_half[k] = COORD_W'((mid_sum[k] + DIV_W'(mid_sum[k][DIV_W-1])) >>> 1);
        end
    end

    assign trial   = r_root + {2'b00, r_bit};
    assign take    = ({1'b0, r_rn} >= trial);
    assign root_nx = take ? ((r_root >> 1) + {2'b00, r_bit}) : (r_root >> 1);

    assign fin_sum  = r_acc + r_prod;
    assign fin_q    = (fin_sum + (fin_sum[PROD_W-1] ? PROD_W'(ONE_FX - 1) : PROD_W'(0)))
                      >>> FX_SHIFT;
    assign fin_p    = (fin_q > PROD_W'(524287))  ? COORD_W'(524287) :
                      (fin_q < -PROD_W'(524288)) ? COORD_W'(-524288) :
                      COORD_W'(fin_q);
    assign ecnt_raw = r_prod[PROD_W-1:FX_SHIFT];

    // operand selection for the shared multiplier and divider
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = r_dist;
        div_den   = DIV_W'(seg_eff);
        case (r_state)
            S_SQ: begin
                if (r_t != 2'd3) begin
                    mul_a = MUL_A_W'(r_d[r_t]);
                    mul_b = MUL_B_W'(r_d[r_t]);
                end
            end
            S_DIVL_GO: begin
                div_start = 1'b1;
            end
            S_DIVS_GO: begin
                div_start = 1'b1;
                div_den   = DIV_W'(sag_eff);
            end
            S_ECNT0: begin
                mul_a = $signed({{(MUL_A_W-DIV_W){1'b0}}, r_lcount});
                mul_b = $signed({{(MUL_B_W-13){1'b0}}, r_reach});
            end
            S_PDIV_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'({r_k, 12'd0});
                div_den   = r_lcount;
            end
            S_TT0: begin
                mul_a = MUL_A_W'(r_tq);
                mul_b = MUL_B_W'(r_tq);
            end
            S_AXIS: begin
                case (r_t)
                    2'd0: begin
                        mul_a = r_we;
                        mul_b = MUL_B_W'(r_e[r_j]);
                    end
                    2'd1: begin
                        mul_a = r_wm;
                        mul_b = MUL_B_W'(r_m[r_j]);
                    end
                    2'd2: begin
                        mul_a = $signed({3'b000, r_r});
                        mul_b = MUL_B_W'(r_s[r_j]);
                    end
                    default: begin
                        mul_a = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // next state and handshake outputs
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) n_state = S_DELTA;
            end
            S_DELTA:     n_state = S_SQ;
            S_SQ:        if (r_t == 2'd3) n_state = S_ROOT;
            S_ROOT:      if (r_bit == 25'd1) n_state = S_DIVL_GO;
            S_DIVL_GO:   n_state = S_DIVL_WAIT;
            S_DIVL_WAIT: if (div_stat.done) n_state = S_DIVS_GO;
            S_DIVS_GO:   n_state = S_DIVS_WAIT;
            S_DIVS_WAIT: if (div_stat.done) n_state = S_ECNT0;
            S_ECNT0:     n_state = S_ECNT1;
            S_ECNT1:     n_state = (ecnt_raw == '0) ? S_IDLE : S_PDIV_GO;
            S_PDIV_GO:   n_state = S_PDIV_WAIT;
            S_PDIV_WAIT: if (div_stat.done) n_state = S_TT0;
            S_TT0:       n_state = S_TT1;
            S_TT1:       n_state = S_AXIS;
            S_AXIS:      if ((r_t == 2'd3) && (r_j == 2'd2)) n_state = S_OUT;
            S_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) n_state = last_pt ? S_IDLE : S_PDIV_GO;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= 16'd256;
            r_sag_div <= 16'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEG_LEN: r_seg_len <= i_cfg_wdata;
                CFG_SAG_DIV: r_sag_div <= i_cfg_wdata;
                default:     r_seg_len <= r_seg_len;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= i_s_axis_tdata[k*COORD_W +: COORD_W];
                        r_e[k] <= i_s_axis_tdata[(3+k)*COORD_W +: COORD_W];
                        r_m[k] <= MID_W'($signed(i_s_axis_tdata[(6+k)*COORD_W +: COORD_W]));
                    end
                    r_reach     <= i_s_axis_tdata[192:180];
                    r_mid_given <= i_s_axis_tuser[0];
                end
            end
            S_DELTA: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= big_c ? d_div[k] : d_raw[k];
                end
                r_big <= big_c;
                r_t   <= 2'd0;
            end
            S_SQ: begin
                r_t <= r_t + 2'd1;
                if (r_t == 2'd1) r_acc <= r_prod;
                if (r_t == 2'd2) r_acc <= fin_sum;
                if (r_t == 2'd3) begin
                    r_rn   <= fin_sum[25:0];
                    r_root <= '0;
                    r_bit  <= 25'd1 << 24;
                end
            end
            S_ROOT: begin
                if (take) r_rn <= 26'(({1'b0, r_rn}) - trial);
                r_root <= root_nx;
                r_bit  <= r_bit >> 2;
                if (r_bit == 25'd1) begin
                    r_dist <= r_big ? {root_nx[12:0], 8'd0} : DIV_W'(root_nx);
                end
            end
            S_DIVL_WAIT: begin
                if (div_stat.done) r_lcount <= div_quo;
            end
            S_DIVS_WAIT: begin
                if (div_stat.done && !r_mid_given) begin
                    r_m[0] <= MID_W'(mid_half[0]);
                    r_m[1] <= MID_W'(mid_half[1]) + $signed({2'b00, div_quo});
                    r_m[2] <= MID_W'(mid_half[2]);
                end
            end
            S_ECNT1: begin
                r_cnt <= (ecnt_raw > (PROD_W-FX_SHIFT)'(MAX_POINTS)) ?
                         CNT_W'(MAX_POINTS) : CNT_W'(ecnt_raw);
                r_k   <= '0;
            end
            S_PDIV_WAIT: begin
                if (div_stat.done) begin
                    r_tq <= COORD_W'(22'sd4096 - $signed({1'b0, div_quo}));
                end
            end
            S_TT1: begin
                r_r  <= r_prod[36:12];
                r_we <= MUL_A_W'(ONE_FX) - (MUL_A_W'(r_tq) <<< 1) +
                        $signed({3'b000, r_prod[36:12]});
                r_wm <= (MUL_A_W'(r_tq) <<< 1) - $signed({2'b00, r_prod[36:12], 1'b0});
                r_t  <= 2'd0;
                r_j  <= 2'd0;
            end
            S_AXIS: begin
                r_t <= r_t + 2'd1;
                if (r_t == 2'd1) r_acc <= r_prod;
                if (r_t == 2'd2) r_acc <= fin_sum;
                if (r_t == 2'd3) begin
                    r_p[r_j] <= fin_p;
                    r_j      <= r_j + 2'd1;
                end
            end
            S_OUT: begin
                if (out_acc && !last_pt) r_k <= r_k + IDX_W'(1);
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_m_axis_tdata = {6'd0, r_k, r_p[2], r_p[1], r_p[0]};
    assign o_m_axis_tlast = last_pt;

    // one wire at a time: never take input while a point is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input taken while a point is pending");

    // the final point of a wire returns the unit to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("unit not idle after final point");

    // a division result only arrives while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> ((r_state == S_DIVL_WAIT) || (r_state == S_DIVS_WAIT) ||
                           (r_state == S_PDIV_WAIT)))
        else $error("divider result outside a wait state");

endmodule
